### rtl/core/mwo_pkg.sv
// Shared constants and codes for the multi-waveform oscillator voice.
// No dependencies; imported by every module of the voice and by its checker.
package mwo_pkg;

    localparam int MWO_SAMPLE_RATE = 48000;
    localparam int MWO_PHASE_BITS  = 32;
    localparam int MWO_SINE_DEPTH  = 1024;

    localparam int REQ_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int LEVEL_W  = 16;
    localparam int WAVE_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // magnitude of a Q15 waveform value, +1.0 included
    localparam int MAG_W  = 17;
    localparam int GAIN_W = 16;

    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

    localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd3;

    localparam logic [GAIN_W-1:0] GAIN_START = 16'd65535;
    localparam logic [GAIN_W-1:0] DECAY_Q16  = 16'd64881;
    localparam logic [MAG_W-1:0]  GAIN_FLOOR = 17'd327;

    // note frequencies of the lowest octave, Q24 Hz
    localparam logic [31:0] NOTE_HZ_Q24 [12] = '{
        32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
        32'd172819773, 32'd183096173, 32'd193983636, 32'd205518503,
        32'd217739269, 32'd230686720, 32'd244404066, 32'd258937089
    };

endpackage

### rtl/core/mwo_mul_round.sv
// Shared multiply unit of the voice: unsigned magnitude times Q0.16, rounded.
// Depends on mwo_pkg.
module mwo_mul_round (
    input  logic [mwo_pkg::MAG_W-1:0]  a,
    input  logic [mwo_pkg::GAIN_W-1:0] b,
    output logic [mwo_pkg::MAG_W-1:0]  y
);
    import mwo_pkg::*;

    localparam int PROD_W = MAG_W + GAIN_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_W - 1);

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(a) * PROD_W'(b) + ROUND_HALF;
    assign y    = prod[GAIN_W +: MAG_W];

endmodule

### rtl/core/mwo_sine_rom.sv
// Sine lookup ROM with registered read, Q15 entries built at elaboration.
// Depends on mwo_pkg.
module mwo_sine_rom #(
    parameter int DEPTH = mwo_pkg::MWO_SINE_DEPTH
) (
    input  logic                          aclk,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    output logic [mwo_pkg::SAMPLE_W-1:0]  q
);
    import mwo_pkg::*;

    localparam logic [63:0] Q28_ONE     = 64'd268435456;
    localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

    function automatic logic [SAMPLE_W-1:0] sine_entry(input int idx);
        logic [63:0] q4, quad, r, ang, a2, t, s, v;
        q4   = 64'(idx) * 64'd4;
        quad = q4 / DEPTH;
        r    = q4 % DEPTH;
        if (quad[0]) r = 64'(DEPTH) - r;
        ang = r * HALF_PI_Q28 / DEPTH;
        a2  = (ang * ang) >> 28;
        t   = Q28_ONE;
        t   = Q28_ONE - ((a2 * t) >> 28) / 110;
        t   = Q28_ONE - ((a2 * t) >> 28) / 72;
        t   = Q28_ONE - ((a2 * t) >> 28) / 42;
        t   = Q28_ONE - ((a2 * t) >> 28) / 20;
        t   = Q28_ONE - ((a2 * t) >> 28) / 6;
        s   = (ang * t) >> 28;
        v   = (s + 64'd4096) >> 13;
        if (v > 64'd32767) v = 64'd32767;
        return (quad >= 64'd2) ? SAMPLE_W'(16'd0 - v[15:0]) : v[SAMPLE_W-1:0];
    endfunction

    logic [SAMPLE_W-1:0] rom_tab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(g);
        assign rom_tab[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        q <= rom_tab[addr];
    end

endmodule

### rtl/core/multi_waveform_oscillator_voice.sv
// Top level of the synthesizer voice: request decode, sequencer, phase and gain state.
// Depends on mwo_pkg, mwo_sine_rom and mwo_mul_round.
//
// One voice driven by a request stream. Note-on and note-off requests keep the sequencer
// idle and produce nothing. A tick of an active voice runs accept, sine ROM read, level
// multiply and output load, with release gain and gain decay multiplies before the load
// while a release fade runs, because one 17x16 rounding multiplier is used in turn for
// the note level, the release gain and the gain decay, and the sine ROM has a registered
// read. Ticks of an inactive voice produce no sample. The finished sample waits in an
// output register, so the next request is taken while it waits; a tick stalls only in
// output load while the old sample is held. SINE_TABLE_DEPTH must be a power of two.
module multi_waveform_oscillator_voice #(
    parameter int SAMPLE_RATE      = mwo_pkg::MWO_SAMPLE_RATE,
    parameter int PHASE_BITS       = mwo_pkg::MWO_PHASE_BITS,
    parameter int SINE_TABLE_DEPTH = mwo_pkg::MWO_SINE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [6:0] note_number, [22:7] velocity, [23] allow_release
    input  logic [mwo_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  logic [mwo_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] sample, [16] voice_active, [23:17] zero
    output logic [mwo_pkg::OUT_DATA_W-1:0]   m_tdata,
    // release_done
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mwo_pkg::WAVE_W-1:0]       cfg_data
);
    import mwo_pkg::*;

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int NOTES  = 1 << NOTE_W;
    localparam int SH     = 48 - PHASE_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_LEVEL = 6'b000100,
        ST_GAIN  = 6'b001000,
        ST_DECAY = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    function automatic logic [63:0] step_of(input int n);
        logic [63:0] num, cps;
        num = 64'(NOTE_HZ_Q24[n % 12]) << (n / 12 + 24);
        cps = (num + 64'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
        if (SH > 0) cps = (cps + (64'd1 << (SH - 1))) >> SH;
        return cps;
    endfunction

    logic [PHASE_BITS-1:0] step_tab [NOTES];

    for (genvar g = 0; g < NOTES; g++) begin : g_step
        localparam logic [63:0] STEP = step_of(g);
        assign step_tab[g] = STEP[PHASE_BITS-1:0];
    end

    state_t                state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_reg, step_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [WAVE_W-1:0]     wave_sel_reg;
    logic [MAG_W-1:0]      prod_reg;
    logic                  sign_reg, done_reg;
    logic                  m_valid_reg;
    logic [SAMPLE_W-1:0]   m_sample_reg;
    logic                  m_active_reg, m_last_reg;

    logic [NOTE_W-1:0]     in_note;
    logic [LEVEL_W-1:0]    in_velocity;
    logic                  in_allow;
    logic                  s_accept, out_free;
    logic [SAMPLE_W-1:0]   rom_q;
    logic [15:0]           f16;
    logic signed [17:0]    wave_val;
    logic [17:0]           wave_neg;
    logic [MAG_W-1:0]      mul_a, mul_y;
    logic [GAIN_W-1:0]     mul_b;
    logic [SAMPLE_W-1:0]   sample_sat;

    assign in_note     = s_tdata[NOTE_W-1:0];
    assign in_velocity = s_tdata[NOTE_W +: LEVEL_W];
    assign in_allow    = s_tdata[NOTE_W + LEVEL_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign f16 = phase_reg[PHASE_BITS-1 -: 16];

    mwo_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk (aclk),
        .addr (phase_reg[PHASE_BITS-1 -: ADDR_W]),
        .q    (rom_q)
    );

    mwo_mul_round u_mul (
        .a (mul_a),
        .b (mul_b),
        .y (mul_y)
    );

    always_comb begin
        case (wave_sel_reg)
            WAVE_SINE:   wave_val = 18'(signed'(rom_q));
            WAVE_SAW:    wave_val = 18'sd32768 - signed'({2'b00, f16});
            WAVE_SQUARE: wave_val = f16[15] ? -18'sd32768 : 18'sd32768;
            WAVE_TRI:    wave_val = f16[15] ? 18'sd98304 - signed'({1'b0, f16, 1'b0})
                                            : -18'sd32768 + signed'({1'b0, f16, 1'b0});
            default:     wave_val = 18'sd0;
        endcase
    end

    assign wave_neg = 18'd0 - 18'(wave_val);

    always_comb begin
        mul_a = prod_reg;
        mul_b = gain_reg;
        unique case (state_reg)
            ST_LEVEL: begin
                mul_a = wave_val[17] ? wave_neg[MAG_W-1:0] : 17'(wave_val);
                mul_b = level_reg;
            end
            ST_DECAY: begin
                mul_a = 17'(gain_reg);
                mul_b = DECAY_Q16;
            end
            default: begin
                mul_a = prod_reg;
                mul_b = gain_reg;
            end
        endcase
    end

    always_comb begin
        if (sign_reg) begin
            sample_sat = SAMPLE_W'(17'd0 - prod_reg);
        end else if (prod_reg > 17'd32767) begin
            sample_sat = 16'h7fff;
        end else begin
            sample_sat = prod_reg[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser == REQ_TICK && step_reg != '0) state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_LEVEL;
            ST_LEVEL: state_next = (gain_reg != '0) ? ST_GAIN : ST_OUT;
            ST_GAIN:  state_next = ST_DECAY;
            ST_DECAY: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            step_reg     <= '0;
            level_reg    <= '0;
            gain_reg     <= '0;
            wave_sel_reg <= WAVE_SINE;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) wave_sel_reg <= cfg_data;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (s_tuser)
                            REQ_NOTE_ON: begin
                                step_reg  <= step_tab[in_note];
                                level_reg <= in_velocity;
                                phase_reg <= '0;
                                gain_reg  <= '0;
                            end
                            REQ_NOTE_OFF: begin
                                if (!in_allow) begin
                                    step_reg <= '0;
                                end else if (gain_reg == '0) begin
                                    gain_reg <= GAIN_START;
                                end
                            end
                            REQ_TICK: done_reg <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                ST_LEVEL: begin
                    prod_reg <= mul_y;
                    sign_reg <= wave_val[17];
                    if (wave_sel_reg <= WAVE_TRI) phase_reg <= phase_reg + step_reg;
                end
                ST_GAIN: prod_reg <= mul_y;
                ST_DECAY: begin
                    if (mul_y <= GAIN_FLOOR) begin
                        gain_reg <= '0;
                        step_reg <= '0;
                        done_reg <= 1'b1;
                    end else begin
                        gain_reg <= mul_y[GAIN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_sample_reg <= sample_sat;
            m_active_reg <= (step_reg != '0);
            m_last_reg   <= done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SAMPLE_W - 1){1'b0}}, m_active_reg, m_sample_reg};
    assign m_tlast  = m_last_reg;

endmodule

### rtl/core/mwo_checker.sv
// Port-level checker for the oscillator voice, bound to the top level.
// Depends on mwo_pkg and multi_waveform_oscillator_voice.
module mwo_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [mwo_pkg::REQ_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mwo_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import mwo_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // the end of a fade always reports a silent voice
    a_done_inactive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[SAMPLE_W])
        else $error("release done with voice still active");

    // note requests never occupy the sequencer
    a_note_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_NOTE_ON || s_tuser == REQ_NOTE_OFF)
        |=> s_tready)
        else $error("note request stalled the input");

    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind multi_waveform_oscillator_voice mwo_checker u_mwo_checker (.*);
